[design/ria_pkg.sv]
// Shared types, codes and defaults for the rotating ID allocator.
`timescale 1ns / 1ps
package ria_pkg;

	localparam int ID_BITS_DEF     = 8;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int WORD_LG         = 5;
	localparam int ACT_W           = 4;
	localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;

	localparam logic [0:0] REG_ACTIVE_BITS = 1'b0;
	localparam logic [0:0] REG_START_POINT = 1'b1;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_REPLACE = 2'd2,
		OP_LOOKUP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_FULL   = 2'd1,
		STS_UNUSED = 2'd2
	} status_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic scan;
		logic eval;
		logic load;
	} ria_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_alloc;
		logic scan_done;
		logic out_free;
	} ria_sts_t;

endpackage

[design/ria_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module ria_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

[design/ria_ctrl.sv]
// Controller state machine that sequences clearing, scans, updates and responses.
`timescale 1ns / 1ps
module ria_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  ria_pkg::ria_sts_t sts,
	output ria_pkg::ria_cmd_t cmd
);
	import ria_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_EVAL  = 5'b01000,
		ST_RESP  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) state_d = sts.in_alloc ? ST_SCAN : ST_EVAL;
			end
			ST_SCAN: begin
				if (sts.scan_done) state_d = ST_RESP;
			end
			ST_EVAL: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready   = (state_q == ST_IDLE);
	assign cmd.clear  = (state_q == ST_CLEAR);
	assign cmd.accept = (state_q == ST_IDLE) && s_tvalid;
	assign cmd.scan   = (state_q == ST_SCAN);
	assign cmd.eval   = (state_q == ST_EVAL);
	assign cmd.load   = (state_q == ST_RESP) && sts.out_free;

`ifndef NO_ASSERTIONS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("controller state is not one-hot");
	a_scan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && !sts.scan_done |=> (state_q == ST_SCAN))
		else $error("scan left before it finished");
	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP) && !sts.out_free |=> (state_q == ST_RESP))
		else $error("response dropped while the output was busy");
`endif
endmodule

[design/ria_dpath.sv]
// Datapath: registers, used-map and value memories, next-fit scan and output stage.
`timescale 1ns / 1ps
module ria_dpath #(
	parameter int ID_BITS     = ria_pkg::ID_BITS_DEF,
	parameter int VALUE_WIDTH = ria_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                cfg_we,
	input  logic [0:0]                                          cfg_index,
	input  logic [((ID_BITS > ria_pkg::ACT_W) ? ID_BITS : ria_pkg::ACT_W)-1:0] cfg_data,
	input  logic [((ID_BITS+VALUE_WIDTH+7)/8)*8-1:0]            s_tdata,
	input  logic [1:0]                                          s_tuser,
	output logic                                                m_tvalid,
	input  logic                                                m_tready,
	output logic [((ID_BITS+VALUE_WIDTH+ID_BITS+1+7)/8)*8-1:0]  m_tdata,
	output logic [2:0]                                          m_tuser,
	input  ria_pkg::ria_cmd_t                                   cmd,
	output ria_pkg::ria_sts_t                                   sts
);
	import ria_pkg::*;

	localparam int WORD_W = 1 << WORD_LG;
	localparam int ADDR_W = (ID_BITS > WORD_LG) ? ID_BITS - WORD_LG : 1;
	localparam int WORDS  = 1 << ADDR_W;
	localparam int EXT_W  = ADDR_W + WORD_LG;
	localparam int CNT_W  = ID_BITS + 1;
	localparam int SH_W   = $clog2(ID_BITS + 1);
	localparam int OUT_DW = ((ID_BITS + VALUE_WIDTH + CNT_W + 7) / 8) * 8;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(1) << ID_BITS;

	logic [ACT_W-1:0]       act_q;
	logic [ID_BITS-1:0]     last_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [ADDR_W-1:0]      clr_q;
	logic [ADDR_W:0]        k_q;
	op_t                    op_q;
	logic [ID_BITS-1:0]     id_q;
	logic [VALUE_WIDTH-1:0] val_q;

	status_t                res_status_q;
	logic [ID_BITS-1:0]     res_id_q;
	logic [VALUE_WIDTH-1:0] res_val_q;
	logic                   res_found_q;

	logic                   m_tvalid_q;
	status_t                out_status_q;
	logic [ID_BITS-1:0]     out_id_q;
	logic [VALUE_WIDTH-1:0] out_val_q;
	logic                   out_found_q;
	logic [CNT_W-1:0]       out_cnt_q;

	logic [SH_W-1:0]        eff_b;
	logic [ID_BITS-1:0]     mask;
	logic [EXT_W-1:0]       mask_ext;
	logic [ADDR_W-1:0]      wmask;
	logic [WORD_LG-1:0]     mlow;
	logic [ID_BITS-1:0]     start;
	logic [EXT_W-1:0]       start_ext;
	logic [ADDR_W-1:0]      sword;
	logic [WORD_LG-1:0]     sbit;
	logic [ADDR_W:0]        nwords;
	logic                   first_pass;
	logic                   last_pass;
	logic [ADDR_W-1:0]      cword;
	logic [ADDR_W-1:0]      nword;

	logic [ID_BITS-1:0]     in_id;
	logic [VALUE_WIDTH-1:0] in_val;
	logic [EXT_W-1:0]       in_ext;
	logic [EXT_W-1:0]       id_ext;
	logic [ADDR_W-1:0]      id_word;
	logic [WORD_LG-1:0]     id_bit;

	logic [WORD_W-1:0]      map_rd;
	logic [WORD_W-1:0]      cand;
	logic                   hit;
	logic [WORD_LG-1:0]     hit_bit;
	logic [EXT_W-1:0]       new_ext;
	logic [ID_BITS-1:0]     new_id;
	logic                   in_use;
	logic                   do_free;
	logic                   do_replace;

	logic                   map_we;
	logic [ADDR_W-1:0]      map_waddr;
	logic [WORD_W-1:0]      map_wdata;
	logic [ADDR_W-1:0]      map_raddr;
	logic                   val_we;
	logic [ID_BITS-1:0]     val_waddr;
	logic [VALUE_WIDTH-1:0] val_rd;

	assign in_id  = s_tdata[ID_BITS-1:0];
	assign in_val = s_tdata[ID_BITS+VALUE_WIDTH-1:ID_BITS];
	assign in_ext = EXT_W'(in_id);

	always_comb begin
		if (act_q == '0) begin
			eff_b = SH_W'(1);
		end else if (act_q > ID_BITS) begin
			eff_b = SH_W'(ID_BITS);
		end else begin
			eff_b = SH_W'(act_q);
		end
	end

	assign mask      = ~({ID_BITS{1'b1}} << eff_b);
	assign mask_ext  = EXT_W'(mask);
	assign wmask     = mask_ext[EXT_W-1:WORD_LG];
	assign mlow      = mask_ext[WORD_LG-1:0];
	assign start     = ID_BITS'(last_q + 1'b1) & mask;
	assign start_ext = EXT_W'(start);
	assign sword     = start_ext[EXT_W-1:WORD_LG];
	assign sbit      = start_ext[WORD_LG-1:0];
	assign nwords    = {1'b0, wmask} + 1'b1;
	assign first_pass = (k_q == '0);
	assign last_pass  = (k_q == nwords);
	assign cword     = ADDR_W'(sword + k_q[ADDR_W-1:0]) & wmask;
	assign nword     = ADDR_W'(sword + k_q[ADDR_W-1:0] + 1'b1) & wmask;

	assign id_ext  = EXT_W'(id_q);
	assign id_word = id_ext[EXT_W-1:WORD_LG];
	assign id_bit  = id_ext[WORD_LG-1:0];

	always_comb begin
		for (int b = 0; b < WORD_W; b++) begin
			cand[b] = !map_rd[b] && ((WORD_LG'(b) & ~mlow) == '0) &&
				(first_pass ? (WORD_LG'(b) >= sbit) :
				 last_pass  ? (WORD_LG'(b) < sbit) : 1'b1);
		end
	end

	always_comb begin
		hit_bit = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (cand[b]) hit_bit = WORD_LG'(b);
		end
	end

	assign hit        = |cand;
	assign new_ext    = {cword, hit_bit};
	assign new_id     = new_ext[ID_BITS-1:0];
	assign in_use     = (id_q <= mask) && map_rd[id_bit];
	assign do_free    = in_use && (op_q == OP_FREE);
	assign do_replace = in_use && (op_q == OP_REPLACE);

	always_comb begin
		map_we    = 1'b0;
		map_waddr = cword;
		map_wdata = map_rd;
		priority if (cmd.clear) begin
			map_we    = 1'b1;
			map_waddr = clr_q;
			map_wdata = '0;
		end else if (cmd.scan && hit) begin
			map_we    = 1'b1;
			map_wdata = map_rd | (WORD_W'(1) << hit_bit);
		end else if (cmd.eval && do_free) begin
			map_we    = 1'b1;
			map_waddr = id_word;
			map_wdata = map_rd & ~(WORD_W'(1) << id_bit);
		end else begin
			map_we = 1'b0;
		end
	end

	assign map_raddr = cmd.accept ?
		((op_t'(s_tuser) == OP_ALLOC) ? sword : in_ext[EXT_W-1:WORD_LG]) : nword;

	assign val_we    = (cmd.scan && hit) || (cmd.eval && do_replace);
	assign val_waddr = cmd.scan ? new_id : id_q;

	ria_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rd)
	);

	ria_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(1 << ID_BITS)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_q),
		.raddr (in_id),
		.rdata (val_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= ACT_RESET;
			last_q <= '0;
			cnt_q  <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + 1'b1;
			if (cfg_we && (cfg_index == REG_ACTIVE_BITS)) act_q <= cfg_data[ACT_W-1:0];
			if (cfg_we && (cfg_index == REG_START_POINT)) begin
				last_q <= cfg_data[ID_BITS-1:0];
			end else if (cmd.scan && hit) begin
				last_q <= new_id;
			end
			if (cmd.scan && hit) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.eval && do_free) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= op_t'(s_tuser);
			id_q  <= in_id;
			val_q <= in_val;
			k_q   <= '0;
		end else if (cmd.scan) begin
			k_q <= k_q + 1'b1;
		end
		if (cmd.scan && (hit || last_pass)) begin
			res_status_q <= hit ? STS_OK : STS_FULL;
			res_id_q     <= hit ? new_id : '0;
			res_val_q    <= '0;
			res_found_q  <= 1'b0;
		end else if (cmd.eval) begin
			res_status_q <= in_use ? STS_OK : STS_UNUSED;
			res_id_q     <= id_q;
			res_val_q    <= (in_use && (op_q == OP_LOOKUP)) ? val_rd : '0;
			res_found_q  <= in_use;
		end
		if (cmd.load) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_val_q    <= res_val_q;
			out_found_q  <= res_found_q;
			out_cnt_q    <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DW'({out_cnt_q, out_val_q, out_id_q});
	assign m_tuser  = {out_found_q, out_status_q};

	assign sts.clr_last  = (clr_q == '1);
	assign sts.in_alloc  = (op_t'(s_tuser) == OP_ALLOC);
	assign sts.scan_done = hit || last_pass;
	assign sts.out_free  = !m_tvalid_q || m_tready;

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_MAX)
		else $error("in-use count beyond the ID space");
	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan && hit && !cfg_we |=> last_q == $past(new_id))
		else $error("last issued ID not updated by an allocation");
	a_free_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval && do_free |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("free did not lower the in-use count");
`endif
endmodule

[design/rotating_id_allocator.sv]
// Top level of the next-fit rotating ID allocator.
//
//   Channel  Direction  Handshake            Contents
//   s_*      in         s_tvalid / s_tready  request word: operation, ID, value
//   m_*      out        m_tvalid / m_tready  response word: status, ID, value, flag, count
//   cfg_*    in         cfg_we               register writes: active bits, start point
//
// After reset a clearing pass zeroes the used map, one 32-bit map word per cycle
// (2^(ID_BITS-5) words, at least 2), and no request word is taken until it ends.
// Free, replace and lookup go from acceptance through the evaluate and response states back to idle.
// Allocate reads k map words in its scan of the used map; the scan reads
// one word per cycle, so k runs from 1 to one more than the words the active space spans.
// A response waits in the output register; the block holds a later one back until it leaves.
`timescale 1ns / 1ps
module rotating_id_allocator #(
	parameter int ID_BITS     = ria_pkg::ID_BITS_DEF,
	parameter int VALUE_WIDTH = ria_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               cfg_we,
	input  logic [0:0]                                         cfg_index,
	input  logic [((ID_BITS > ria_pkg::ACT_W) ? ID_BITS : ria_pkg::ACT_W)-1:0] cfg_data,
	input  logic                                               s_tvalid,
	output logic                                               s_tready,
	// id, value
	input  logic [((ID_BITS+VALUE_WIDTH+7)/8)*8-1:0]           s_tdata,
	// operation
	input  logic [1:0]                                         s_tuser,
	output logic                                               m_tvalid,
	input  logic                                               m_tready,
	// result_id, result_value, used_count
	output logic [((ID_BITS+VALUE_WIDTH+ID_BITS+1+7)/8)*8-1:0] m_tdata,
	// status, found
	output logic [2:0]                                         m_tuser
);
	import ria_pkg::*;

	ria_cmd_t cmd;
	ria_sts_t sts;

	ria_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ria_dpath #(.ID_BITS(ID_BITS), .VALUE_WIDTH(VALUE_WIDTH)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule

[verif/rotating_id_allocator_tb.sv]
// Self-checking testbench for the rotating ID allocator: request stream, predicted responses.
`timescale 1ns / 1ps
module rotating_id_allocator_tb;
	import ria_pkg::*;

	typedef struct {
		op_t         op;
		logic [7:0]  id;
		logic [31:0] value;
	} request_t;

	typedef struct {
		status_t     status;
		logic [7:0]  id;
		logic [31:0] value;
		logic        found;
		logic [8:0]  count;
	} response_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = REG_ACTIVE_BITS;
	logic [7:0]  cfg_data = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = 40'd0;
	logic [1:0]  s_tuser = 2'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [2:0]  m_tuser;

	rotating_id_allocator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #1 clk = ~clk;

	// Shadow copy of the allocator state.
	bit          id_used [256];
	logic [31:0] id_value [256];
	logic [7:0]  last_id;
	logic [8:0]  ids_in_use;
	logic [3:0]  act_bits_cfg;

	request_t  pend_q[$];
	response_t resp_q[$];
	request_t  cur_req;

	int send_idle = 29;
	int recv_idle = 74;
	logic      hold_start = 1'b0;
	int        hold_left = 0;
	int        err_cnt = 0;
	int        n_ok = 0, n_full = 0, n_unused = 0, peak_count = 0, n_sent = 0;

	task automatic report(input string what);
		if (err_cnt < 40)
			$display("MISMATCH at %0t ns: %s", $time, what);
		err_cnt++;
	endtask

	function automatic logic [7:0] id_mask();
		int b;
		b = act_bits_cfg;
		if (b < 1)
			b = 1;
		if (b > 8)
			b = 8;
		return 8'((1 << b) - 1);
	endfunction

	function automatic response_t predict_response(input request_t rq);
		response_t r;
		logic [7:0] mask;
		logic [7:0] cand;
		bit got;
		bit inuse;
		r.status = STS_OK;
		r.id = 8'd0;
		r.value = 32'd0;
		r.found = 1'b0;
		mask = id_mask();
		if (rq.op == OP_ALLOC) begin
			cand = (last_id + 8'd1) & mask;
			got = 1'b0;
			for (int n = 0; n <= mask && !got; n++) begin
				if (!id_used[cand])
					got = 1'b1;
				else
					cand = (cand + 8'd1) & mask;
			end
			if (got) begin
				id_used[cand] = 1'b1;
				id_value[cand] = rq.value;
				ids_in_use++;
				last_id = cand;
				r.id = cand;
			end else begin
				r.status = STS_FULL;
			end
		end else begin
			inuse = (rq.id <= mask) && id_used[rq.id];
			r.id = rq.id;
			if (!inuse) begin
				r.status = STS_UNUSED;
			end else begin
				r.found = 1'b1;
				case (rq.op)
					OP_FREE: begin
						id_used[rq.id] = 1'b0;
						ids_in_use--;
					end
					OP_REPLACE: id_value[rq.id] = rq.value;
					default: r.value = id_value[rq.id];
				endcase
			end
		end
		r.count = ids_in_use;
		case (r.status)
			STS_OK: n_ok++;
			STS_FULL: n_full++;
			default: n_unused++;
		endcase
		if (ids_in_use > peak_count)
			peak_count = ids_in_use;
		return r;
	endfunction

	// Request driver.
	always @(posedge clk) begin
		request_t nxt;
		logic give;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				resp_q.push_back(predict_response(cur_req));
				n_sent++;
			end
			if (!s_tvalid || s_tready) begin
				give = (pend_q.size() > 0) && ($urandom_range(99) >= send_idle);
				if (give) begin
					nxt = pend_q.pop_front();
					cur_req <= nxt;
					s_tdata <= {nxt.value, nxt.id};
					s_tuser <= nxt.op;
				end
				s_tvalid <= give;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_start)
			hold_left <= 400;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// Response monitor.
	always @(posedge clk) begin
		response_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (resp_q.size() == 0) begin
					report("response word with nothing expected");
				end else begin
					want = resp_q.pop_front();
					if (m_tuser[1:0] !== want.status)
						report($sformatf("status got %0d want %0d", m_tuser[1:0], want.status));
					if (m_tdata[7:0] !== want.id)
						report($sformatf("id got %0d want %0d", m_tdata[7:0], want.id));
					if (m_tdata[39:8] !== want.value)
						report($sformatf("value got %h want %h", m_tdata[39:8], want.value));
					if (m_tuser[2] !== want.found)
						report($sformatf("found got %b want %b", m_tuser[2], want.found));
					if (m_tdata[48:40] !== want.count)
						report($sformatf("count got %0d want %0d", m_tdata[48:40], want.count));
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic cfg_write(input logic [0:0] idx, input logic [7:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == REG_ACTIVE_BITS) begin
			act_bits_cfg = data[3:0];
		end else begin
			last_id = data;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (pend_q.size() > 0 || s_tvalid || resp_q.size() > 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic push_req(input op_t op, input logic [7:0] id, input logic [31:0] value);
		request_t rq;
		rq.op = op;
		rq.id = id;
		rq.value = value;
		pend_q.push_back(rq);
	endtask

	task automatic start_phase(input logic [3:0] act, input logic [7:0] start, input int s_idle,
			input int r_idle);
		settle();
		cfg_write(REG_ACTIVE_BITS, {4'd0, act});
		cfg_write(REG_START_POINT, start);
		send_idle = s_idle;
		recv_idle = r_idle;
	endtask

	task automatic gen_random(input int n, input int alloc_pct);
		op_t op;
		logic [7:0] id;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < alloc_pct)
				op = OP_ALLOC;
			else
				op = op_t'($urandom_range(3, 1));
			if (op == OP_ALLOC || $urandom_range(3) == 0)
				id = 8'($urandom);
			else
				id = 8'($urandom) & id_mask();
			push_req(op, id, $urandom);
		end
	endtask

	initial begin
		for (int i = 0; i < 256; i++) begin
			id_used[i] = 1'b0;
			id_value[i] = 32'd0;
		end
		act_bits_cfg = ACT_RESET;
		last_id = 8'd0;
		ids_in_use = 9'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(negedge clk);
		while (!s_tready);

		start_phase(4'd8, 8'd0, 29, 74);
		push_req(OP_LOOKUP, 8'd0, 32'd0);
		push_req(OP_ALLOC, 8'd0, 32'd0);
		push_req(OP_ALLOC, 8'hFF, 32'hFFFF_FFFF);
		push_req(OP_LOOKUP, 8'd1, 32'd0);
		push_req(OP_REPLACE, 8'd1, 32'hA5A5_A5A5);
		push_req(OP_LOOKUP, 8'd1, 32'hFFFF_FFFF);
		push_req(OP_FREE, 8'd2, 32'd0);
		push_req(OP_FREE, 8'd2, 32'd0);
		push_req(OP_REPLACE, 8'd2, 32'h5A5A_5A5A);
		push_req(OP_LOOKUP, 8'hFF, 32'd0);
		push_req(OP_ALLOC, 8'h55, 32'h1234_5678);
		push_req(OP_LOOKUP, 8'd3, 32'd0);

		// A tiny space: wraparound, full table, and IDs left over from the wider space.
		start_phase(4'd1, 8'hFF, 29, 74);
		push_req(OP_ALLOC, 8'd0, 32'hDEAD_BEEF);
		push_req(OP_ALLOC, 8'd0, 32'h0000_0001);
		push_req(OP_ALLOC, 8'd0, 32'h8000_0000);
		push_req(OP_LOOKUP, 8'd3, 32'd0);
		push_req(OP_FREE, 8'd3, 32'd0);
		push_req(OP_LOOKUP, 8'd200, 32'd0);
		push_req(OP_FREE, 8'd1, 32'd0);
		push_req(OP_ALLOC, 8'd0, 32'hCAFE_F00D);
		push_req(OP_LOOKUP, 8'd0, 32'd0);
		push_req(OP_LOOKUP, 8'd1, 32'd0);

		start_phase(4'd4, 8'($urandom), 29, 74);
		gen_random(150, 40);

		// Fill the whole space while the response side stalls for a long stretch.
		start_phase(4'd8, 8'($urandom), 74, 29);
		gen_random(280, 92);
		@(posedge clk);
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;

		start_phase(4'd2, 8'($urandom), 74, 29);
		gen_random(100, 30);

		start_phase(4'd15, 8'hFF, 0, 0);
		gen_random(150, 45);

		start_phase(4'd0, 8'd0, 0, 0);
		gen_random(70, 40);

		settle();
		repeat (20) @(posedge clk);
		if (resp_q.size() > 0)
			report($sformatf("%0d expected response words never arrived", resp_q.size()));
		$display("Covered %0d request words: %0d succeeded, %0d hit a full table, %0d named unused IDs.",
			n_sent, n_ok, n_full, n_unused);
		$display("Peak IDs in use %0d, across active widths 0 to 15 and a long output stall.",
			peak_count);
		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
